// File: rtl/core/spq_pkg.sv
// Shared types, constants and helper functions for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // Sizing of the queue and of the stored fields.
  localparam int CAPACITY     = 16;
  localparam int KEY_BITS     = 20;
  localparam int PAYLOAD_BITS = 32;
  localparam int CNT_BITS     = $clog2(CAPACITY + 1);

  // Operation codes carried in the func field.
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Key selection codes.
  localparam logic KEY_EXPIRE  = 1'b0;
  localparam logic KEY_DELIVER = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One stored entry.
  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] payload;
    logic [KEY_BITS-1:0]     expire;
    logic [KEY_BITS-1:0]     deliver;
  } entry_t;

  // Control broadcast to every cell of the row.
  typedef struct packed {
    logic enq;
    logic deq;
    logic key_select;
  } spq_ctrl_t;

  // Returns the key that currently orders the queue.
  function automatic logic [KEY_BITS-1:0] sel_key(input entry_t e, input logic ks);
    return (ks == KEY_DELIVER) ? e.deliver : e.expire;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/spq_in_if.sv
// Request channel of the sorted priority queue: valid, ready and the request word.
`timescale 1ns / 1ps
`default_nettype none

interface spq_in_if
  import spq_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [PAYLOAD_BITS-1:0] payload;
  logic [KEY_BITS-1:0]     expire_key;
  logic [KEY_BITS-1:0]     deliver_key;

  modport source (output valid, output func, output payload, output expire_key,
                  output deliver_key, input ready);
  modport sink   (input valid, input func, input payload, input expire_key,
                  input deliver_key, output ready);
endinterface

`default_nettype wire

// File: rtl/core/spq_out_if.sv
// Result channel of the sorted priority queue: valid, ready and the result word.
`timescale 1ns / 1ps
`default_nettype none

interface spq_out_if
  import spq_pkg::*;
();
  logic                    valid;
  logic                    ready;
  status_t                 status;
  logic [PAYLOAD_BITS-1:0] out_payload;
  logic [KEY_BITS-1:0]     out_expire;
  logic [KEY_BITS-1:0]     out_deliver;
  logic [CNT_BITS-1:0]     entry_count;
  logic                    head_due;

  modport source (output valid, output status, output out_payload, output out_expire,
                  output out_deliver, output entry_count, output head_due,
                  input ready);
  modport sink   (input valid, input status, input out_payload, input out_expire,
                  input out_deliver, input entry_count, input head_due,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/core/spq_cell.sv
// One slot of the sorted queue row: holds an entry and shifts with its neighbours.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic      clk,
  input  wire spq_ctrl_t ctrl,
  input  wire entry_t    new_entry,
  input  wire entry_t    left_entry,
  input  wire entry_t    right_entry,
  input  wire logic      occupied,
  input  wire logic      left_after,
  input  wire logic      right_after,
  output logic           after,
  output entry_t         entry,
  output entry_t         entry_next
);

  logic greater;

  // The new word may pass this slot when it is empty or holds a strictly larger key.
  assign greater = !occupied ||
                   (sel_key(new_entry, ctrl.key_select) < sel_key(entry, ctrl.key_select));

  // True when the new word lands at or before this slot: every slot from here on passes.
  assign after = greater && right_after;

  // On insert, slots behind the insertion point take their left neighbour, the
  // insertion slot takes the new word; on removal every slot takes its right neighbour.
  always_comb begin
    entry_next = entry;
    if (ctrl.enq) begin
      if (left_after) begin
        entry_next = left_entry;
      end else if (after) begin
        entry_next = new_entry;
      end
    end else if (ctrl.deq) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

// File: rtl/core/sorted_priority_queue.sv
// Top level of the sorted priority queue: cell row, entry count and result register.
//
// A bounded priority queue of CAPACITY entries, each a payload with an expiry and
// a delivery key. Requests arrive on in_ch: func selects enqueue or dequeue. An
// enqueue places the word behind every entry whose ordering key is not greater
// than its own; a dequeue returns the head, the entry with the least key.
// Every request yields exactly one word on out_ch with a status (ok, full or
// empty), the removed entry on a good dequeue (zero otherwise), the entry count
// after the operation and head_due, set when the head's ordering key is zero.
// cfg_we/cfg_wdata write key_select (0 expiry key, 1 delivery key); the user must
// write it only while idle (not enforced). One request is taken per cycle unless
// the receiver stalls: every cell compares against the new key in parallel and
// the row shifts in a single step, so the compare and the shift of the cell row
// set the rate. The result register holds one word; while it is held because the
// receiver stalls, in_ch.ready is low, and it rises in the cycle the word is
// taken. Reset empties the queue, clears key_select and the result valid flag;
// the stored entries and the result fields are not cleared and need no clearing
// pass, since only occupied cells and valid result words are ever looked at.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch,
  input  wire logic  cfg_we,
  input  wire logic  cfg_wdata
);

  logic                    key_select;
  logic [CNT_BITS-1:0]     count;
  logic [CNT_BITS-1:0]     count_next;
  logic                    out_valid;
  status_t                 status;
  status_t                 status_next;
  entry_t                  result;
  entry_t                  result_next;
  logic                    head_due;
  logic                    head_due_next;
  logic                    accepted;
  logic                    full;
  logic                    empty;
  logic                    enq_ok;
  logic                    deq_ok;
  spq_ctrl_t               ctrl;
  entry_t                  new_entry;
  entry_t                  cells     [CAPACITY];
  entry_t                  cells_nxt [CAPACITY];
  logic                    after     [CAPACITY];

  // Handshake: a new word is taken whenever the result register is free or draining.
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accepted    = in_ch.valid && in_ch.ready;
  assign full        = (count == CNT_BITS'(CAPACITY));
  assign empty       = (count == '0);
  assign enq_ok      = accepted && (in_ch.func == FUNC_ENQ) && !full;
  assign deq_ok      = accepted && (in_ch.func == FUNC_DEQ) && !empty;

  assign ctrl.enq        = enq_ok;
  assign ctrl.deq        = deq_ok;
  assign ctrl.key_select = key_select;

  assign new_entry.payload = in_ch.payload;
  assign new_entry.expire  = in_ch.expire_key;
  assign new_entry.deliver = in_ch.deliver_key;

  // Row of cells; the head is cell 0 and the tail end is fed with "all passed".
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_a;
    logic   right_a;

    if (j == 0) begin : g_head
      assign left_e = new_entry;
      assign left_a = 1'b0;
    end else begin : g_mid
      assign left_e = cells[j-1];
      assign left_a = after[j-1];
    end

    if (j == CAPACITY - 1) begin : g_tail
      assign right_e = cells[j];
      assign right_a = 1'b1;
    end else begin : g_body
      assign right_e = cells[j+1];
      assign right_a = after[j+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .right_entry (right_e),
      .occupied    (CNT_BITS'(j) < count),
      .left_after  (left_a),
      .right_after (right_a),
      .after       (after[j]),
      .entry       (cells[j]),
      .entry_next  (cells_nxt[j])
    );
  end

  // Next entry count and the result word of the accepted request.
  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    result_next = '0;
    if (enq_ok) begin
      count_next = count + CNT_BITS'(1);
    end else if (deq_ok) begin
      count_next  = count - CNT_BITS'(1);
      result_next = cells[0];
    end else if (accepted && (in_ch.func == FUNC_ENQ)) begin
      status_next = ST_FULL;
    end else if (accepted) begin
      status_next = ST_EMPTY;
    end
    head_due_next = (count_next != '0) && (sel_key(cells_nxt[0], key_select) == '0);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_select <= KEY_EXPIRE;
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        key_select <= cfg_wdata;
      end
      count <= count_next;
      if (accepted) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (accepted) begin
      status   <= status_next;
      result   <= result_next;
      head_due <= head_due_next;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.status      = status;
  assign out_ch.out_payload = result.payload;
  assign out_ch.out_expire  = result.expire;
  assign out_ch.out_deliver = result.deliver;
  assign out_ch.entry_count = count;
  assign out_ch.head_due    = head_due;

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(CAPACITY))
    else $error("entry count above capacity");

  // A rejected enqueue reports full and leaves the count as it was.
  a_full_reject: assert property (@(posedge clk) disable iff (rst)
    accepted && (in_ch.func == FUNC_ENQ) && full
    |=> out_valid && (status == ST_FULL) && (count == CNT_BITS'(CAPACITY)))
    else $error("enqueue on a full queue not rejected");

  // A good dequeue lowers the count by one.
  a_deq_count: assert property (@(posedge clk) disable iff (rst)
    deq_ok |=> (count == $past(count) - CNT_BITS'(1)) && (status == ST_OK))
    else $error("dequeue did not lower the count");

  // A due head is only reported for a non-empty queue.
  a_due_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && head_due |-> (count != '0))
    else $error("head due reported on an empty queue");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for the sorted priority queue: random traffic against a predictor.
`timescale 1ns / 1ps

module testbench;
  import spq_pkg::*;

  // Expected content of one result word.
  typedef struct {
    status_t                 status;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [KEY_BITS-1:0]     expire;
    logic [KEY_BITS-1:0]     deliver;
    logic [CNT_BITS-1:0]     count;
    logic                    due;
  } queue_result_t;

  // Tracks the queue contents and holds the result words still to come.
  class spq_tracker;
    entry_t          slots [CAPACITY];
    int unsigned     fill;
    logic            key_sel;
    queue_result_t   awaited [$];
    int unsigned     errors;
    int unsigned     reports;

    function new();
      fill    = 0;
      key_sel = KEY_EXPIRE;
      errors  = 0;
      reports = 0;
    endfunction

    function void select_key(logic ks);
      key_sel = ks;
    endfunction

    function int unsigned outstanding();
      return awaited.size();
    endfunction

    function logic [KEY_BITS-1:0] ordering_key(entry_t e);
      return (key_sel == KEY_DELIVER) ? e.deliver : e.expire;
    endfunction

    // Applies one accepted request to the tracked queue and records its result.
    function void note_request(logic op, logic [PAYLOAD_BITS-1:0] pl,
                               logic [KEY_BITS-1:0] ek, logic [KEY_BITS-1:0] dk);
      queue_result_t r;
      entry_t        fresh;
      int            pos;
      r.status  = ST_OK;
      r.payload = '0;
      r.expire  = '0;
      r.deliver = '0;
      if (op == FUNC_ENQ) begin
        if (fill >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          fresh.payload = pl;
          fresh.expire  = ek;
          fresh.deliver = dk;
          pos = fill;
          // The new entry moves forward only past strictly greater keys.
          while (pos > 0 && ordering_key(fresh) < ordering_key(slots[pos-1])) begin
            slots[pos] = slots[pos-1];
            pos--;
          end
          slots[pos] = fresh;
          fill++;
        end
      end else begin
        if (fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.payload = slots[0].payload;
          r.expire  = slots[0].expire;
          r.deliver = slots[0].deliver;
          for (int i = 1; i < fill; i++) slots[i-1] = slots[i];
          fill--;
        end
      end
      r.count = CNT_BITS'(fill);
      r.due   = (fill > 0) && (ordering_key(slots[0]) == '0);
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, logic [63:0] want_v, logic [63:0] got_v);
      if (got_v !== want_v) begin
        errors++;
        if (reports < 60) begin
          reports++;
          $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, name, want_v,
                   got_v);
        end
      end
    endfunction

    // Compares one accepted result word with the oldest outstanding one.
    function void check_result(queue_result_t got);
      queue_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (reports < 60) begin
          reports++;
          $display("%0t ns: unexpected result word: expected none, actual status %0d",
                   $time, got.status);
        end
        return;
      end
      want = awaited.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("out_payload", want.payload, got.payload);
      compare_field("out_expire", want.expire, got.expire);
      compare_field("out_deliver", want.deliver, got.deliver);
      compare_field("entry_count", want.count, got.count);
      compare_field("head_due", want.due, got.due);
    endfunction
  endclass

  localparam int HOLD_CYCLES = 120;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  logic quiet_mode;
  int   holds_asked;

  spq_tracker    tracker;
  queue_result_t seen_result;

  spq_in_if  req_ch ();
  spq_out_if rsp_ch ();

  sorted_priority_queue dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (req_ch),
    .out_ch    (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Clock with a 12 ns period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog on the whole run.
  initial begin
    #2_000_000;
    $display("testbench: FAIL");
    $finish;
  end

  // Note each accepted request word, then check each accepted result word.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        tracker.note_request(req_ch.func, req_ch.payload, req_ch.expire_key,
                             req_ch.deliver_key);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen_result.status  = rsp_ch.status;
        seen_result.payload = rsp_ch.out_payload;
        seen_result.expire  = rsp_ch.out_expire;
        seen_result.deliver = rsp_ch.out_deliver;
        seen_result.count   = rsp_ch.entry_count;
        seen_result.due     = rsp_ch.head_due;
        tracker.check_result(seen_result);
      end
    end
  end

  // Receiver: random stalls, plus a long hold whenever one is asked for.
  initial begin
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left    = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        hold_left    = HOLD_CYCLES;
      end
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        rsp_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        rsp_ch.ready <= quiet_mode || ($urandom_range(99) >= 12);
      end
    end
  end

  // Keys lean towards zero, small values and the top of the range.
  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return KEY_BITS'($urandom_range(3));
      3:       return KEY_BITS'($urandom_range(15));
      default: return KEY_BITS'($urandom);
    endcase
  endfunction

  // Offers one request word, after a random gap, and waits until it is taken.
  task automatic send_request(input logic op, input logic [PAYLOAD_BITS-1:0] pl,
                              input logic [KEY_BITS-1:0] ek,
                              input logic [KEY_BITS-1:0] dk);
    while (!quiet_mode && $urandom_range(99) < 12) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.func        <= op;
    req_ch.payload     <= pl;
    req_ch.expire_key  <= ek;
    req_ch.deliver_key <= dk;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Stops offering and waits until every result word has come back. The first
  // edge lets the monitor note the last request before the count is looked at.
  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_key_select(input logic ks);
    cfg_we    <= 1'b1;
    cfg_wdata <= ks;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.select_key(ks);
  endtask

  // Random traffic that swings between filling and draining the queue.
  task automatic run_phase(input int items);
    int enq_pct;
    enq_pct = $urandom_range(1) ? 75 : 30;
    for (int n = 0; n < items; n++) begin
      if (n % 24 == 0) enq_pct = (enq_pct == 75) ? 30 : 75;
      send_request(($urandom_range(99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ, $urandom,
                   pick_key(), pick_key());
    end
  endtask

  // Main sequence.
  initial begin
    logic [PAYLOAD_BITS-1:0] pl;
    logic [KEY_BITS-1:0]     ek;
    logic [KEY_BITS-1:0]     dk;
    tracker            = new();
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = 1'b0;
    quiet_mode         = 1'b0;
    holds_asked        = 0;
    req_ch.valid       = 1'b0;
    req_ch.func        = FUNC_ENQ;
    req_ch.payload     = '0;
    req_ch.expire_key  = '0;
    req_ch.deliver_key = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_key_select(KEY_EXPIRE);

    // Directed: empty dequeue, extreme fields, equal keys, fill up and overflow.
    send_request(FUNC_DEQ, '0, '0, '0);
    for (int i = 0; i < CAPACITY; i++) begin
      pl = (i == 0) ? '0 : (i == 1) ? '1 : PAYLOAD_BITS'($urandom);
      case (i)
        0:          ek = '0;
        1:          ek = '1;
        2, 3, 4, 5: ek = KEY_BITS'(5);
        6:          ek = KEY_BITS'(20'h55555);
        7:          ek = KEY_BITS'(20'hAAAAA);
        default:    ek = pick_key();
      endcase
      dk = (i == 0) ? '1 : (i == 1) ? '0 : pick_key();
      send_request(FUNC_ENQ, pl, ek, dk);
    end
    send_request(FUNC_ENQ, '1, '0, '0);
    repeat (7) send_request(FUNC_DEQ, $urandom, pick_key(), pick_key());
    drain();

    // Switch ordering with entries still held; the receiver holds off meanwhile.
    write_key_select(KEY_DELIVER);
    holds_asked = holds_asked + 1;
    run_phase(210);
    drain();

    // A stretch with no idling on either side.
    write_key_select(KEY_EXPIRE);
    quiet_mode = 1'b1;
    run_phase(210);
    drain();
    quiet_mode = 1'b0;

    write_key_select(KEY_DELIVER);
    run_phase(210);
    drain();

    write_key_select(KEY_EXPIRE);
    run_phase(210);
    drain();

    if (tracker.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
